@@ src/babylonian_square_root_unit_defines.svh @@
// assertion macros shared by the square root unit modules
// depends on clk_i and rst_ni being present in the module that uses them
`ifndef BABYLONIAN_SQUARE_ROOT_UNIT_DEFINES_SVH
`define BABYLONIAN_SQUARE_ROOT_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define BSR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");
// next-cycle implication
`define BSR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");
`else
`define BSR_ASSERT_NOW(lbl, ante, cons)
`define BSR_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ src/bsr_pkg.sv @@
// shared constants and controller/datapath interface types of the square root unit
// no dependencies
package bsr_pkg;

  localparam int FRAC_BITS = 16;
  localparam int MAX_ITER  = 32;
  localparam int OPERAND_W = 32;
  localparam int ROOT_W    = 24;
  localparam int ITER_W    = 6;
  // guess and quotient hold the full shifted dividend width
  localparam int GUESS_W   = OPERAND_W + FRAC_BITS;
  localparam int CNT_W     = $clog2(GUESS_W);
  // room for a product by a constant below 128
  localparam int MUL_W     = GUESS_W + 7;
  localparam int TOL_LO    = 100;
  localparam int TOL_HI    = 101;

  // controller to datapath
  typedef struct packed {
    logic              init;
    logic              div_start;
    logic              div_step;
    logic              update;
    logic              load_out;
    logic [ITER_W-1:0] iterations;
    logic              capped;
  } bsr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic x_zero;
    logic tol_ok;
    logic out_busy;
  } bsr_status_t;

endpackage

@@ src/bsr_dpath.sv @@
// datapath of the square root unit: operand, guess, restoring divider, output register
// depends on bsr_pkg and the assertion macro header
`include "babylonian_square_root_unit_defines.svh"

module bsr_dpath import bsr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_fire_i,
  input  logic [OPERAND_W-1:0] operand_i,
  input  bsr_cmd_t             cmd_i,
  output bsr_status_t          status_o,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output logic [ROOT_W-1:0]    root_o,
  output logic [ITER_W-1:0]    iterations_o,
  output logic                 capped_o
);

  logic [OPERAND_W-1:0] x_q;
  logic [GUESS_W-1:0]   guess_q, guess_d;
  logic [GUESS_W-1:0]   old_q;
  logic [GUESS_W-1:0]   rem_q, rem_d;
  logic [GUESS_W-1:0]   quo_q, quo_d;
  logic                 out_valid_q;
  logic [ROOT_W-1:0]    root_q;
  logic [ITER_W-1:0]    iter_q;
  logic                 capped_q;

  logic [GUESS_W:0]     trial;
  logic [GUESS_W:0]     diff;
  logic [GUESS_W:0]     sum;
  logic [GUESS_W-1:0]   half_x;
  logic [GUESS_W-1:0]   avg;
  logic [MUL_W-1:0]     old_lo, old_hi, new_lo, new_hi;
  logic [ROOT_W-1:0]    root_sat;
  logic                 out_fire;

  // absolute value of the operand, the most negative code maps to its magnitude
  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      x_q <= operand_i[OPERAND_W-1] ? (~operand_i + OPERAND_W'(1)) : operand_i;
    end
  end

  // one restoring divider step
  always_comb begin
    trial = {rem_q, quo_q[GUESS_W-1]};
    diff  = trial - {1'b0, guess_q};
    if (!diff[GUESS_W]) begin
      rem_d = diff[GUESS_W-1:0];
      quo_d = {quo_q[GUESS_W-2:0], 1'b1};
    end else begin
      rem_d = trial[GUESS_W-1:0];
      quo_d = {quo_q[GUESS_W-2:0], 1'b0};
    end
  end

  // start guess and averaged guess, both kept at least one
  always_comb begin
    half_x = GUESS_W'(x_q >> 1);
    sum    = {1'b0, guess_q} + {1'b0, quo_q};
    avg    = sum[GUESS_W:1];
    guess_d = guess_q;
    if (cmd_i.init) begin
      guess_d = (half_x == '0) ? GUESS_W'(1) : half_x;
    end else if (cmd_i.update) begin
      guess_d = (avg == '0) ? GUESS_W'(1) : avg;
    end
  end

  // guess, previous guess and divider registers
  always_ff @(posedge clk_i) begin
    guess_q <= guess_d;
    if (cmd_i.update) begin
      old_q <= guess_q;
    end
    if (cmd_i.div_start) begin
      rem_q <= '0;
      quo_q <= {x_q, FRAC_BITS'(0)};
    end else if (cmd_i.div_step) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  // tolerance test by cross products with the ratio bounds
  always_comb begin
    old_lo = MUL_W'(old_q) * MUL_W'(TOL_LO);
    old_hi = MUL_W'(old_q) * MUL_W'(TOL_HI);
    new_lo = MUL_W'(guess_q) * MUL_W'(TOL_LO);
    new_hi = MUL_W'(guess_q) * MUL_W'(TOL_HI);
  end

  // saturate the root to the output width
  assign root_sat = (guess_q > GUESS_W'({ROOT_W{1'b1}})) ? {ROOT_W{1'b1}}
                                                         : guess_q[ROOT_W-1:0];

  assign out_fire = out_valid_q && !out_stall_i;

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      root_q   <= (x_q == '0) ? '0 : root_sat;
      iter_q   <= cmd_i.iterations;
      capped_q <= cmd_i.capped;
    end
  end

  assign status_o.x_zero   = (x_q == '0);
  assign status_o.tol_ok   = (old_lo <= new_hi) && (new_lo <= old_hi);
  assign status_o.out_busy = out_valid_q && out_stall_i;

  assign out_valid_o  = out_valid_q;
  assign root_o       = root_q;
  assign iterations_o = iter_q;
  assign capped_o     = capped_q;

  // a new guess is never zero, so the divider never sees a zero divisor
  `BSR_ASSERT_NEXT(a_guess_nonzero, cmd_i.init || cmd_i.update, guess_q != '0)
  // a result is never written over one still waiting
  `BSR_ASSERT_NOW(a_no_overwrite, cmd_i.load_out, !(out_valid_q && out_stall_i))

endmodule

@@ src/bsr_ctrl.sv @@
// controller of the square root unit: sequences divide, update and tolerance check
// depends on bsr_pkg and the assertion macro header
`include "babylonian_square_root_unit_defines.svh"

module bsr_ctrl import bsr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_fire_i,
  output logic        in_stall_o,
  input  bsr_status_t status_i,
  output bsr_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_DIV,
    ST_UPDATE,
    ST_CHECK,
    ST_FINISH
  } state_e;

  state_e            state_q;
  logic [CNT_W-1:0]  bit_cnt_q;
  logic [ITER_W-1:0] iter_q;
  logic              capped_q;
  logic              last_bit;
  logic              at_cap;

  assign last_bit = (bit_cnt_q == CNT_W'(GUESS_W - 1));
  assign at_cap   = (iter_q == ITER_W'(MAX_ITER));

  // state, step counters and result flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      bit_cnt_q <= '0;
      iter_q    <= '0;
      capped_q  <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire_i) begin
            state_q <= ST_INIT;
          end
        end
        ST_INIT: begin
          iter_q    <= '0;
          capped_q  <= 1'b0;
          bit_cnt_q <= '0;
          state_q   <= status_i.x_zero ? ST_FINISH : ST_DIV;
        end
        ST_DIV: begin
          bit_cnt_q <= bit_cnt_q + CNT_W'(1);
          if (last_bit) begin
            state_q <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          iter_q  <= iter_q + ITER_W'(1);
          state_q <= ST_CHECK;
        end
        ST_CHECK: begin
          priority if (status_i.tol_ok) begin
            state_q <= ST_FINISH;
          end else if (at_cap) begin
            capped_q <= 1'b1;
            state_q  <= ST_FINISH;
          end else begin
            bit_cnt_q <= '0;
            state_q   <= ST_DIV;
          end
        end
        ST_FINISH: begin
          if (!status_i.out_busy) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // commands decoded from state
  always_comb begin
    cmd_o            = '0;
    cmd_o.iterations = iter_q;
    cmd_o.capped     = capped_q;
    unique case (state_q)
      ST_INIT: begin
        cmd_o.init      = 1'b1;
        cmd_o.div_start = 1'b1;
      end
      ST_DIV:    cmd_o.div_step  = 1'b1;
      ST_UPDATE: cmd_o.update    = 1'b1;
      ST_CHECK:  cmd_o.div_start = !status_i.tol_ok && !at_cap;
      ST_FINISH: cmd_o.load_out  = !status_i.out_busy;
      default:   cmd_o.init      = 1'b0;
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  // the cap flag only comes with the full step count
  `BSR_ASSERT_NOW(a_cap_count, capped_q, iter_q == ITER_W'(MAX_ITER))
  // the bit counter stays inside the divide width
  `BSR_ASSERT_NOW(a_div_range, state_q == ST_DIV, bit_cnt_q <= CNT_W'(GUESS_W - 1))
  // an accepted beat always starts a new root
  `BSR_ASSERT_NEXT(a_start, in_fire_i, state_q == ST_INIT)

endmodule

@@ src/babylonian_square_root_unit.sv @@
// square root of |operand| by repeated Babylonian steps; operand Q16.16, root Q8.16
// a zero operand skips the steps and goes straight to the output register; else each
// step is one pass of the radix-2 restoring divider, which sets the pace, then the
// guess update and the tolerance check
// throughput: one item at a time; the next beat is taken once the result is in the
// output register, even while that result is still stalled
// reset: asynchronous, clears controller state and output valid; no memories to clear
module babylonian_square_root_unit import bsr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [OPERAND_W-1:0] operand_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [ROOT_W-1:0]    root_o,
  output logic [ITER_W-1:0]    iterations_o,
  output logic                 capped_o
);

  bsr_cmd_t    cmd;
  bsr_status_t status;
  logic        in_fire;

  // input beat accepted
  assign in_fire = in_valid_i && !in_stall_o;

  bsr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_fire_i  (in_fire),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bsr_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_fire_i    (in_fire),
    .operand_i    (operand_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .root_o       (root_o),
    .iterations_o (iterations_o),
    .capped_o     (capped_o)
  );

endmodule
